### hdl/spr_pkg.sv
package spr_pkg;

   localparam int CAPACITY     = 16;
   localparam int HANDLE_WIDTH = 16;
   localparam int ID_W         = 32;
   localparam int CNT_W        = $clog2(CAPACITY + 1);
   localparam int OUT_CNT_W    = 5;

   typedef enum logic [2:0] {
      REQ_ADD    = 3'd0,
      REQ_REMOVE = 3'd1,
      REQ_PURGE  = 3'd2,
      REQ_QUERY  = 3'd3,
      REQ_CLEAR  = 3'd4
   } req_code_type;

   typedef struct packed {
      logic [HANDLE_WIDTH-1:0] handle;
      logic [ID_W-1:0]         id;
      logic                    rel;
      logic                    mark;
   } entry_type;

   typedef struct packed {
      logic                    ins_en;
      logic                    mark_en;
      logic                    del_en;
      logic                    first_only;
      logic                    by_handle;
      logic [HANDLE_WIDTH-1:0] handle;
      logic [ID_W-1:0]         id;
      logic                    rel;
   } cell_cmd_type;

endpackage

### hdl/spr_cell.sv
module spr_cell import spr_pkg::*; (
   input  logic         clock,
   input  cell_cmd_type cmd,
   input  logic         occ,
   input  entry_type    prev_entry,
   input  entry_type    next_entry,
   input  logic         gt_seen_in,
   input  logic         mark_seen_in,
   input  logic         match_seen_in,
   output entry_type    entry_out,
   output logic         gt_seen_out,
   output logic         mark_seen_out,
   output logic         match_seen_out,
   output logic         hit_out
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      gt_here;
   logic      match_here;

   // An empty slot counts as larger, so an insert with no larger id lands
   // at the back. An unreliable add treats every slot as larger and lands
   // at the front.
   assign gt_here        = !cmd.rel || !occ || (entry_ff.id > cmd.id);
   assign gt_seen_out    = gt_seen_in || gt_here;
   assign match_here     = occ && (cmd.by_handle ? (entry_ff.handle == cmd.handle)
                                                 : (entry_ff.id == cmd.id));
   assign match_seen_out = match_seen_in || match_here;
   assign mark_seen_out  = mark_seen_in || entry_ff.mark;
   assign hit_out        = occ && entry_ff.rel && (entry_ff.id == cmd.id);
   assign entry_out      = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins_en) begin
         if (gt_seen_in) begin
            entry_in      = prev_entry;
            entry_in.mark = 1'b0;
         end else if (gt_here) begin
            entry_in.handle = cmd.handle;
            entry_in.id     = cmd.id;
            entry_in.rel    = cmd.rel;
            entry_in.mark   = 1'b0;
         end
      end else if (cmd.mark_en) begin
         entry_in.mark = match_here && !(cmd.first_only && match_seen_in);
      end else if (cmd.del_en) begin
         // The frontmost marked slot and everything behind it move up by one.
         if (mark_seen_out) begin
            entry_in = next_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

### hdl/sorted_packet_retain_list.sv
// Add, query, clear and unused codes: S_EXEC produces the result, which is registered
// into the response (held in S_DONE while the response output is stalled).
// Remove and purge: S_EXEC marks the matching entries, then S_SQUEEZE removes them,
// one slot compaction per cycle. A new request is taken only back in S_IDLE.
// Synchronous active-high reset empties the list; slot contents are not cleared.
module sorted_packet_retain_list import spr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_type,
   input  logic [15:0]          req_entry_handle,
   input  logic [ID_W-1:0]      req_packet_id,
   input  logic                 req_reliable,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_accepted,
   output logic                 rsp_hit,
   output logic [OUT_CNT_W-1:0] rsp_removed_count,
   output logic [OUT_CNT_W-1:0] rsp_occupancy
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SQUEEZE,
      S_DONE
   } state_type;

   state_type               state_ff;
   logic [2:0]              code_ff;
   logic [HANDLE_WIDTH-1:0] handle_ff;
   logic [ID_W-1:0]         id_ff;
   logic                    rel_ff;
   logic [CNT_W-1:0]        fill_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic                    res_acc_ff;
   logic                    res_hit_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_acc_ff;
   logic                    rsp_hit_ff;
   logic [OUT_CNT_W-1:0]    rsp_cnt_ff;
   logic [OUT_CNT_W-1:0]    rsp_occ_ff;

   cell_cmd_type            cmd;
   entry_type               entries [CAPACITY];
   logic [CAPACITY:0]       gt_chain;
   logic [CAPACITY:0]       mark_chain;
   logic [CAPACITY:0]       match_chain;
   logic [CAPACITY-1:0]     hits;
   logic [CAPACITY-1:0]     occ;

   logic                    is_add;
   logic                    is_remove;
   logic                    is_purge;
   logic                    full;
   logic                    any_mark;
   logic                    out_free;
   logic                    fin_go;
   logic                    fin_acc;
   logic                    fin_hit;
   logic [CNT_W-1:0]        fin_cnt;
   logic [CNT_W-1:0]        fill_in;

   assign is_add    = (code_ff == REQ_ADD);
   assign is_remove = (code_ff == REQ_REMOVE);
   assign is_purge  = (code_ff == REQ_PURGE);
   assign full      = (fill_ff >= CNT_W'(CAPACITY));
   assign any_mark  = mark_chain[CAPACITY];
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd            = '0;
      cmd.ins_en     = (state_ff == S_EXEC) && is_add && !full;
      cmd.mark_en    = (state_ff == S_EXEC) && (is_remove || is_purge);
      cmd.del_en     = (state_ff == S_SQUEEZE) && any_mark;
      cmd.first_only = is_remove;
      cmd.by_handle  = is_remove;
      cmd.handle     = handle_ff;
      cmd.id         = id_ff;
      cmd.rel        = rel_ff;
   end

   assign gt_chain[0]    = 1'b0;
   assign mark_chain[0]  = 1'b0;
   assign match_chain[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type prev_e;
      entry_type next_e;

      assign occ[i] = (CNT_W'(i) < fill_ff);

      if (i == 0) begin : g_first
         assign prev_e = '0;
      end else begin : g_mid
         assign prev_e = entries[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next_e = '0;
      end else begin : g_inner
         assign next_e = entries[i+1];
      end

      spr_cell u_cell (
         .clock          (clock),
         .cmd            (cmd),
         .occ            (occ[i]),
         .prev_entry     (prev_e),
         .next_entry     (next_e),
         .gt_seen_in     (gt_chain[i]),
         .mark_seen_in   (mark_chain[i]),
         .match_seen_in  (match_chain[i]),
         .entry_out      (entries[i]),
         .gt_seen_out    (gt_chain[i+1]),
         .mark_seen_out  (mark_chain[i+1]),
         .match_seen_out (match_chain[i+1]),
         .hit_out        (hits[i])
      );
   end

   // Result of the request that completes in this cycle, if any.
   always_comb begin
      fin_go  = 1'b0;
      fin_acc = 1'b1;
      fin_hit = 1'b0;
      fin_cnt = '0;
      fill_in = fill_ff;
      case (state_ff)
         S_EXEC: begin
            case (code_ff)
               REQ_ADD: begin
                  fin_go = 1'b1;
                  if (full) begin
                     fin_acc = 1'b0;
                  end else begin
                     fill_in = fill_ff + CNT_W'(1);
                  end
               end
               REQ_REMOVE, REQ_PURGE: begin
                  fin_go = 1'b0;
               end
               REQ_QUERY: begin
                  fin_go  = 1'b1;
                  fin_hit = |hits;
               end
               REQ_CLEAR: begin
                  fin_go  = 1'b1;
                  fin_cnt = fill_ff;
                  fill_in = '0;
               end
               default: begin
                  fin_go = 1'b1;
               end
            endcase
         end
         S_SQUEEZE: begin
            fin_hit = res_hit_ff;
            fin_cnt = cnt_ff;
            if (any_mark) begin
               fill_in = fill_ff - CNT_W'(1);
            end else begin
               fin_go = 1'b1;
            end
         end
         S_DONE: begin
            fin_go  = 1'b1;
            fin_acc = res_acc_ff;
            fin_hit = res_hit_ff;
            fin_cnt = cnt_ff;
         end
         default: begin
            fin_go = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (fin_go && out_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_acc_ff   <= fin_acc;
            rsp_hit_ff   <= fin_hit;
            rsp_cnt_ff   <= OUT_CNT_W'(fin_cnt);
            rsp_occ_ff   <= OUT_CNT_W'(fill_in);
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  code_ff   <= req_type;
                  handle_ff <= HANDLE_WIDTH'(req_entry_handle);
                  id_ff     <= req_packet_id;
                  rel_ff    <= req_reliable;
                  state_ff  <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (is_remove || is_purge) begin
                  cnt_ff     <= '0;
                  res_hit_ff <= is_remove && match_chain[CAPACITY];
                  state_ff   <= S_SQUEEZE;
               end else if (out_free) begin
                  state_ff <= S_IDLE;
               end else begin
                  res_acc_ff <= fin_acc;
                  res_hit_ff <= fin_hit;
                  cnt_ff     <= fin_cnt;
                  state_ff   <= S_DONE;
               end
            end
            S_SQUEEZE: begin
               if (any_mark) begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end else if (out_free) begin
                  state_ff <= S_IDLE;
               end else begin
                  res_acc_ff <= 1'b1;
                  state_ff   <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_acc_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_removed_count = rsp_cnt_ff;
   assign rsp_occupancy     = rsp_occ_ff;

endmodule
